// ----- hw/rtl/tscs_pkg.sv -----
// ============================================================================
// tscs_pkg
// Shared constants for the seeded cluster search unit: default geometry,
// command codes, configuration register indexes and reset values, result kinds.
// ============================================================================
package tscs_pkg;

  localparam int MAX_PADS_DEF    = 256;
  localparam int TIME_BINS_DEF   = 512;
  localparam int CHARGE_BITS_DEF = 10;

  // command codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PADS_IN_ROW = 2'd0;
  localparam logic [1:0] REG_PAD_WINDOW  = 2'd1;
  localparam logic [1:0] REG_TIME_WINDOW = 2'd2;

  // reset values of the configuration registers
  localparam logic [8:0] PADS_IN_ROW_RST = 9'd256;
  localparam logic [4:0] PAD_WINDOW_RST  = 5'd6;
  localparam logic [5:0] TIME_WINDOW_RST = 6'd8;

  // result kinds
  localparam logic [1:0] KIND_ZERO   = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

endpackage

// ----- hw/rtl/track_seeded_cluster_search_unit.sv -----
// ============================================================================
// track_seeded_cluster_search_unit
// Pad-row charge grid with used marks and a seeded cluster search.
// ============================================================================
// Usage: command words enter on in_* (valid/ready) and each one gives one
// result word on out_* (valid/ready). Commands: clear grid, write digit,
// search cluster, read digit. The user must write configuration (cfg_we/
// cfg_index/cfg_wdata) only while idle, which the unit does not enforce;
// it takes effect on the next command. The grid lives in one single-port
// synchronous RAM of MAX_PADS*TIME_BINS words {used, charge}; all timing
// follows from that port. A clear writes one RAM word per cycle over the
// whole grid. A search reads each grid cell it visits and marks those that
// hold charge; if charge was found, four bit-serial divisions then share one
// divider, with NW-bit quotients (NW = 54 at default sizes).
// One command is in flight at a time; in_ready is high only when idle.
// Reset: control state clears, then a clearing pass writes every RAM word
// with in_ready low.
// Stall: a finished result waits in the output register until taken; the
// unit holds its last state until out_ready frees the register.
// ============================================================================
module track_seeded_cluster_search_unit
  import tscs_pkg::*;
#(
  parameter int MAX_PADS    = MAX_PADS_DEF,
  parameter int TIME_BINS   = TIME_BINS_DEF,
  parameter int CHARGE_BITS = CHARGE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_pad,
  input  logic [8:0]  in_time_bin,
  input  logic [9:0]  in_charge,
  input  logic        in_hit_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [23:0] out_charge_sum,
  output logic [15:0] out_pad_centre,
  output logic [16:0] out_time_centre,
  output logic [23:0] out_pad_variance,
  output logic [23:0] out_time_variance,
  output logic [8:0]  out_pads_used,
  output logic [9:0]  out_read_charge,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam int PW    = $clog2(MAX_PADS);
  localparam int TW    = $clog2(TIME_BINS);
  localparam int DEPTH = MAX_PADS * TIME_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = CHARGE_BITS + AW;
  localparam int SPW   = QW + PW;
  localparam int STW   = QW + TW;
  localparam int SPPW  = QW + 2 * PW;
  localparam int STTW  = QW + 2 * TW;
  localparam int MXW   = (SPPW > STTW) ? SPPW : STTW;
  localparam int NW    = MXW + 9;
  localparam int CMPW  = NW + 1;
  localparam int DCW   = $clog2(NW);
  localparam int PCW   = PW + 2;
  localparam int TCW   = TW + 2;
  localparam int NPW   = $clog2(MAX_PADS + 1);
  localparam int CW    = PW + 8;
  localparam int CTW   = TW + 8;
  localparam int MWW   = CHARGE_BITS + 1;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RDCMD  = 4'd2;
  localparam logic [3:0] S_PSTART = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_EV     = 4'd5;
  localparam logic [3:0] S_PEND   = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_SQ     = 4'd9;
  localparam logic [3:0] S_VAR    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  // grid RAM
  logic [MWW-1:0] grid_mem [DEPTH];
  logic [MWW-1:0] rd_q_r;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_addr;
  logic [MWW-1:0] mem_wd;

  // control
  logic [3:0]    state_r;
  logic [AW-1:0] clr_addr_r;
  logic          clr_cmd_r;
  logic [1:0]    kind_r;
  logic [8:0]    pads_r;
  logic [4:0]    pwin_r;
  logic [5:0]    twin_r;

  // search walk
  logic signed [PCW-1:0] pad_r, seed_p_r;
  logic signed [TCW-1:0] t_r, seed_t_r;
  logic                  up_p_r, up_t_r, seqnz_r;
  logic [2*PW-1:0]       pad2_r;
  logic [2*TW-1:0]       t2_r;
  logic [AW-1:0]         addr_r;
  logic [NPW-1:0]        npads_r;

  // moments
  logic [QW-1:0]   q_r;
  logic [SPW-1:0]  sp_r;
  logic [STW-1:0]  st_r;
  logic [SPPW-1:0] spp_r;
  logic [STTW-1:0] stt_r;

  // divider and finish
  logic [NW-1:0]   div_nq_r;
  logic [QW-1:0]   div_rem_r;
  logic [DCW-1:0]  div_cnt_r;
  logic [1:0]      div_idx_r;
  logic [CW-1:0]   cp_r;
  logic [CTW-1:0]  ct_r;
  logic [NW-1:0]   mp_r, mt_r;
  logic [2*CW-1:0] sqp_r;
  logic [2*CTW-1:0] sqt_r;
  logic [NW-1:0]   varp_r, vart_r;
  logic [9:0]      rdval_r;

  logic out_valid_r;

  // ---------------------------------------------------------------- decode
  logic                   in_fire, in_inside;
  logic [AW-1:0]          in_addr;
  logic [CHARGE_BITS-1:0] wq;
  logic [PCW-1:0]         limit_c;
  logic signed [PCW-1:0]  lim_s;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_inside = (32'(in_pad) < MAX_PADS) && (32'(in_time_bin) < TIME_BINS);
  assign in_addr   = AW'(AW'(in_pad) * AW'(TIME_BINS)) + AW'(in_time_bin);
  assign wq        = CHARGE_BITS'(in_charge);
  assign limit_c   = (32'(pads_r) < MAX_PADS) ? PCW'(pads_r) : PCW'(MAX_PADS);
  assign lim_s     = $signed(limit_c);

  // walk conditions
  logic                   t_ok, ev_nz, near_t, near_p, pad_out;
  logic [AW-1:0]          walk_addr;
  logic [CHARGE_BITS-1:0] ev_q;
  logic signed [TCW:0]    dt, dt_abs;
  logic signed [PCW:0]    dp, dp_abs;

  assign t_ok = !t_r[TCW-1] && ($signed(t_r) < $signed(TCW'(TIME_BINS)));
  assign walk_addr = AW'(AW'(pad_r[PW-1:0]) * AW'(TIME_BINS)) + AW'(t_r[TW-1:0]);
  assign ev_q  = rd_q_r[CHARGE_BITS-1:0];
  assign ev_nz = (ev_q != '0);
  assign dt     = {t_r[TCW-1], t_r} - {seed_t_r[TCW-1], seed_t_r};
  assign dt_abs = dt[TCW] ? -dt : dt;
  assign near_t = (dt_abs <= $signed((TCW+1)'(twin_r[5:1])));
  assign dp     = {pad_r[PCW-1], pad_r} - {seed_p_r[PCW-1], seed_p_r};
  assign dp_abs = dp[PCW] ? -dp : dp;
  assign near_p = (dp_abs <= $signed((PCW+1)'(pwin_r[4:1])));
  assign pad_out = pad_r[PCW-1] || (pad_r >= lim_s);

  // per-cell products
  logic [PW+CHARGE_BITS-1:0]   prod_p;
  logic [TW+CHARGE_BITS-1:0]   prod_t;
  logic [2*PW+CHARGE_BITS-1:0] prod_pp;
  logic [2*TW+CHARGE_BITS-1:0] prod_tt;

  assign prod_p  = pad_r[PW-1:0] * ev_q;
  assign prod_t  = t_r[TW-1:0] * ev_q;
  assign prod_pp = pad2_r * ev_q;
  assign prod_tt = t2_r * ev_q;

  // divider step: restoring, one quotient bit per cycle
  logic [QW:0]   rem_sh, rem_sub;
  logic          div_ge, div_last;
  logic [NW-1:0] div_nq_n;

  assign rem_sh   = {div_rem_r, div_nq_r[NW-1]};
  assign div_ge   = (rem_sh >= {1'b0, q_r});
  assign rem_sub  = rem_sh - {1'b0, q_r};
  assign div_nq_n = {div_nq_r[NW-2:0], div_ge};
  assign div_last = (div_cnt_r == DCW'(NW - 1));

  // numerator of the following division
  logic [NW-1:0] div_num_next;
  always_comb begin
    case (div_idx_r)
      2'd0:    div_num_next = (NW'(st_r) << 8) + NW'(q_r >> 1);
      2'd1:    div_num_next = (NW'(spp_r) << 8) + NW'(q_r >> 1);
      default: div_num_next = (NW'(stt_r) << 8) + NW'(q_r >> 1);
    endcase
  end

  // rounded squares of the centres
  logic [2*CW-8:0]  ccp;
  logic [2*CTW-8:0] cct;

  assign ccp = (2*CW-7)'(({1'b0, sqp_r} + (2*CW+1)'(128)) >> 8);
  assign cct = (2*CTW-7)'(({1'b0, sqt_r} + (2*CTW+1)'(128)) >> 8);

  // ---------------------------------------------------------------- RAM port
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = walk_addr;
    mem_wd   = {1'b1, ev_q};
    case (state_r)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr_r;
        mem_wd   = '0;
      end
      S_IDLE: begin
        mem_addr = in_addr;
        mem_wd   = {1'b0, wq};
        mem_we   = in_fire && (in_func == FUNC_WRITE) && in_inside;
        mem_re   = in_fire && (in_func == FUNC_READ) && in_inside;
      end
      S_RD: begin
        mem_re = t_ok;
      end
      S_EV: begin
        mem_addr = addr_r;
        mem_we   = ev_nz;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= grid_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pads_r <= PADS_IN_ROW_RST;
      pwin_r <= PAD_WINDOW_RST;
      twin_r <= TIME_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PADS_IN_ROW: pads_r <= cfg_wdata;
        REG_PAD_WINDOW:  pwin_r <= cfg_wdata[4:0];
        REG_TIME_WINDOW: twin_r <= cfg_wdata[5:0];
        default:         pads_r <= pads_r;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_addr_r <= '0;
      clr_cmd_r  <= 1'b0;
      kind_r     <= KIND_ZERO;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            kind_r  <= KIND_ZERO;
            state_r <= clr_cmd_r ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            kind_r <= (in_func == FUNC_READ) ? KIND_READ : KIND_ZERO;
            case (in_func)
              FUNC_CLEAR: begin
                clr_cmd_r  <= 1'b1;
                clr_addr_r <= '0;
                state_r    <= S_CLR;
              end
              FUNC_WRITE: begin
                state_r <= S_OUT;
              end
              FUNC_SEARCH: begin
                q_r      <= '0;
                sp_r     <= '0;
                st_r     <= '0;
                spp_r    <= '0;
                stt_r    <= '0;
                npads_r  <= '0;
                up_p_r   <= 1'b0;
                pad_r    <= PCW'(in_pad);
                seed_p_r <= PCW'(in_pad);
                seed_t_r <= TCW'(in_time_bin);
                if (in_hit_valid && (32'(in_pad) < 32'(limit_c)) &&
                    (32'(in_time_bin) < TIME_BINS)) begin
                  state_r <= S_PSTART;
                end else begin
                  state_r <= S_OUT;
                end
              end
              default: begin
                rdval_r <= '0;
                state_r <= in_inside ? S_RDCMD : S_OUT;
              end
            endcase
          end
        end
        S_RDCMD: begin
          rdval_r <= rd_q_r[CHARGE_BITS] ? 10'd0 : 10'(rd_q_r[CHARGE_BITS-1:0]);
          state_r <= S_OUT;
        end
        S_PSTART: begin
          if (pad_out) begin
            state_r <= S_FIN;
          end else begin
            t_r     <= seed_t_r;
            up_t_r  <= 1'b0;
            seqnz_r <= 1'b0;
            pad2_r  <= pad_r[PW-1:0] * pad_r[PW-1:0];
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (t_ok) begin
            addr_r  <= walk_addr;
            t2_r    <= t_r[TW-1:0] * t_r[TW-1:0];
            state_r <= S_EV;
          end else begin
            state_r <= S_PEND;
          end
        end
        S_EV: begin
          if (ev_nz) begin
            q_r     <= q_r + QW'(ev_q);
            sp_r    <= sp_r + SPW'(prod_p);
            st_r    <= st_r + STW'(prod_t);
            spp_r   <= spp_r + SPPW'(prod_pp);
            stt_r   <= stt_r + STTW'(prod_tt);
            seqnz_r <= 1'b1;
            t_r     <= up_t_r ? t_r + TCW'(1) : t_r - TCW'(1);
            state_r <= S_RD;
          end else if (!seqnz_r && near_t) begin
            // widen over empty bins
            t_r     <= up_t_r ? t_r + TCW'(1) : t_r - TCW'(1);
            state_r <= S_RD;
          end else if (!up_t_r) begin
            t_r     <= seed_t_r + TCW'(1);
            up_t_r  <= 1'b1;
            state_r <= S_RD;
          end else begin
            state_r <= S_PEND;
          end
        end
        S_PEND: begin
          if (seqnz_r) begin
            pad_r   <= up_p_r ? pad_r + PCW'(1) : pad_r - PCW'(1);
            npads_r <= npads_r + NPW'(1);
            state_r <= S_PSTART;
          end else if (!up_p_r) begin
            if ((q_r == '0) && near_p && (pad_r > $signed(PCW'(0)))) begin
              pad_r <= pad_r - PCW'(1);
            end else begin
              pad_r  <= seed_p_r + PCW'(1);
              up_p_r <= 1'b1;
            end
            state_r <= S_PSTART;
          end else if ((q_r == '0) && near_p && (pad_r < lim_s - $signed(PCW'(2)))) begin
            pad_r   <= pad_r + PCW'(1);
            state_r <= S_PSTART;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (q_r == '0) begin
            state_r <= S_OUT;
          end else begin
            kind_r    <= KIND_SEARCH;
            div_idx_r <= 2'd0;
            div_cnt_r <= '0;
            div_rem_r <= '0;
            div_nq_r  <= (NW'(sp_r) << 8) + NW'(q_r >> 1);
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_last) begin
            case (div_idx_r)
              2'd0:    cp_r <= CW'(div_nq_n);
              2'd1:    ct_r <= CTW'(div_nq_n);
              2'd2:    mp_r <= div_nq_n;
              default: mt_r <= div_nq_n;
            endcase
            // reload for the next division
            div_nq_r  <= div_num_next;
            div_cnt_r <= '0;
            div_rem_r <= '0;
            div_idx_r <= div_idx_r + 2'd1;
            if (div_idx_r == 2'd3) begin
              state_r <= S_SQ;
            end
          end else begin
            div_nq_r  <= div_nq_n;
            div_rem_r <= div_ge ? rem_sub[QW-1:0] : rem_sh[QW-1:0];
            div_cnt_r <= div_cnt_r + DCW'(1);
          end
        end
        S_SQ: begin
          sqp_r   <= cp_r * cp_r;
          sqt_r   <= ct_r * ct_r;
          state_r <= S_VAR;
        end
        S_VAR: begin
          varp_r  <= (CMPW'(mp_r) > CMPW'(ccp)) ? NW'(CMPW'(mp_r) - CMPW'(ccp)) : '0;
          vart_r  <= (CMPW'(mt_r) > CMPW'(cct)) ? NW'(CMPW'(mt_r) - CMPW'(cct)) : '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            clr_cmd_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  logic sat_q, sat_cp, sat_ct, sat_vp, sat_vt, sat_np;
  logic out_load, srch_w, rd_w;

  assign sat_q  = CMPW'(q_r) > CMPW'(24'hFFFFFF);
  assign sat_cp = CMPW'(cp_r) > CMPW'(16'hFFFF);
  assign sat_ct = CMPW'(ct_r) > CMPW'(17'h1FFFF);
  assign sat_vp = CMPW'(varp_r) > CMPW'(24'hFFFFFF);
  assign sat_vt = CMPW'(vart_r) > CMPW'(24'hFFFFFF);
  assign sat_np = CMPW'(npads_r) > CMPW'(9'h1FF);

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign srch_w   = (kind_r == KIND_SEARCH);
  assign rd_w     = (kind_r == KIND_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // fields a command does not produce stay zero
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found         <= srch_w;
      out_charge_sum    <= !srch_w ? 24'd0 : sat_q ? 24'hFFFFFF : 24'(q_r);
      out_pad_centre    <= !srch_w ? 16'd0 : sat_cp ? 16'hFFFF : 16'(cp_r);
      out_time_centre   <= !srch_w ? 17'd0 : sat_ct ? 17'h1FFFF : 17'(ct_r);
      out_pad_variance  <= !srch_w ? 24'd0 : sat_vp ? 24'hFFFFFF : 24'(varp_r);
      out_time_variance <= !srch_w ? 24'd0 : sat_vt ? 24'hFFFFFF : 24'(vart_r);
      out_pads_used     <= !srch_w ? 9'd0 : sat_np ? 9'h1FF : 9'(npads_r);
      out_read_charge   <= rd_w ? rdval_r : 10'd0;
      out_saturated     <= srch_w && (sat_q | sat_cp | sat_ct | sat_vp | sat_vt | sat_np);
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------- checks
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready)
    else $error("command taken during clearing pass");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken while one is in flight");

  a_found_has_charge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_charge_sum != 24'd0))
    else $error("found word with zero charge");

  a_ram_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_CLR) || (state_r == S_IDLE) || (state_r == S_EV)))
    else $error("grid written outside clear, write or mark");

endmodule

// ----- dv/track_seeded_cluster_search_unit_tb.sv -----
// ============================================================================
// track_seeded_cluster_search_unit_tb
// Self-checking bench for the seeded cluster search unit. A generator queues
// command words (digit writes, reads, clears and cluster searches, mostly
// written clusters followed by a search near them). A clocked driver offers
// them on in_*. A shadow charge grid predicts every result word on out_*,
// and the monitor compares it as one word. Idle and stall rates change
// per phase, and so do the row geometry registers.
// ============================================================================
module track_seeded_cluster_search_unit_tb;
  import tscs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPADS  = MAX_PADS_DEF;
  localparam int NBINS  = TIME_BINS_DEF;
  localparam int NCELLS = NPADS * NBINS;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] pad;
    logic [8:0] time_bin;
    logic [9:0] charge;
    logic       hit_valid;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [23:0] charge_sum;
    logic [15:0] pad_centre;
    logic [16:0] time_centre;
    logic [23:0] pad_variance;
    logic [23:0] time_variance;
    logic [8:0]  pads_used;
    logic [9:0]  read_charge;
    logic        saturated;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_CLEAR;
  logic [7:0]  in_pad = '0;
  logic [8:0]  in_time_bin = '0;
  logic [9:0]  in_charge = '0;
  logic        in_hit_valid = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_found;
  logic [23:0] out_charge_sum;
  logic [15:0] out_pad_centre;
  logic [16:0] out_time_centre;
  logic [23:0] out_pad_variance;
  logic [23:0] out_time_variance;
  logic [8:0]  out_pads_used;
  logic [9:0]  out_read_charge;
  logic        out_saturated;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_PADS_IN_ROW;
  logic [8:0]  cfg_wdata = '0;

  track_seeded_cluster_search_unit dut (.*);

  // shadow grid and registers
  logic [9:0]      grid_q [NCELLS];
  bit              grid_used [NCELLS];
  longint unsigned m_q, m_p, m_t, m_pp, m_tt;
  int              row_pads = 256;
  int              pad_win = 6;
  int              time_win = 8;

  cmd_t pending_cmds [$];
  res_t results_due [$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_kick = 0;
  int   hold_seen = 0;
  int   hold_cnt = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("track_seeded_cluster_search_unit_tb: errors");
    $finish;
  end

  function automatic int absdiff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic longint unsigned scan_one_pad(int p, int seed_t, int half_t);
    longint unsigned seq, q;
    int t, dir, idx;
    seq = 0;
    t = seed_t;
    dir = -1;
    forever begin
      if (t < 0 || t >= NBINS) break;
      idx = p * NBINS + t;
      q = grid_q[idx];
      if (q == 0) begin
        if (seq == 0 && absdiff(t, seed_t) <= half_t) begin
          t += dir;
          continue;
        end
        if (dir == -1) begin
          t = seed_t + 1;
          dir = 1;
          continue;
        end
        break;
      end
      seq += q;
      m_q += q;
      m_p += longint'(p) * q;
      m_t += longint'(t) * q;
      m_pp += longint'(p) * longint'(p) * q;
      m_tt += longint'(t) * longint'(t) * q;
      grid_used[idx] = 1'b1;
      t += dir;
    end
    return seq;
  endfunction

  function automatic longint unsigned q8_spread(longint unsigned s, longint unsigned ss,
                                               longint unsigned q);
    longint unsigned c, m, cc;
    c = (256 * s + q / 2) / q;
    m = (256 * ss + q / 2) / q;
    cc = (c * c + 128) >> 8;
    return m > cc ? m - cc : 0;
  endfunction

  function automatic longint unsigned clip(longint unsigned v, longint unsigned mx,
                                          ref bit sat);
    if (v > mx) begin
      sat = 1'b1;
      return mx;
    end
    return v;
  endfunction

  function automatic res_t cluster_search(int seed_p, int seed_t);
    res_t r;
    int lim, half_p, half_t, p, dir;
    longint unsigned seq, npads;
    bit sat, empty, near;
    r = '0;
    lim = row_pads < NPADS ? row_pads : NPADS;
    half_p = pad_win / 2;
    half_t = time_win / 2;
    p = seed_p;
    dir = -1;
    npads = 0;
    sat = 1'b0;
    m_q = 0; m_p = 0; m_t = 0; m_pp = 0; m_tt = 0;
    forever begin
      if (p < 0 || p >= lim) break;
      seq = scan_one_pad(p, seed_t, half_t);
      if (seq != 0) begin
        p += dir;
        npads++;
        continue;
      end
      empty = (m_q == 0);
      near = absdiff(p, seed_p) <= half_p;
      if (dir == -1) begin
        if (empty && near && p > 0) p--;
        else begin
          p = seed_p + 1;
          dir = 1;
        end
        continue;
      end
      if (empty && near && p < lim - 2) begin
        p++;
        continue;
      end
      break;
    end
    if (m_q == 0) return r;
    r.found = 1'b1;
    r.charge_sum = 24'(clip(m_q, 24'hFFFFFF, sat));
    r.pad_centre = 16'(clip((256 * m_p + m_q / 2) / m_q, 16'hFFFF, sat));
    r.time_centre = 17'(clip((256 * m_t + m_q / 2) / m_q, 17'h1FFFF, sat));
    r.pad_variance = 24'(clip(q8_spread(m_p, m_pp, m_q), 24'hFFFFFF, sat));
    r.time_variance = 24'(clip(q8_spread(m_t, m_tt, m_q), 24'hFFFFFF, sat));
    r.pads_used = 9'(clip(npads, 9'h1FF, sat));
    r.saturated = sat;
    return r;
  endfunction

  function automatic res_t grid_command(cmd_t c);
    res_t r;
    int idx;
    r = '0;
    idx = int'(c.pad) * NBINS + int'(c.time_bin);
    case (c.func)
      FUNC_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) begin
          grid_q[i] = '0;
          grid_used[i] = 1'b0;
        end
      end
      FUNC_WRITE: begin
        grid_q[idx] = c.charge;
        grid_used[idx] = 1'b0;
      end
      FUNC_SEARCH: begin
        if (c.hit_valid) r = cluster_search(c.pad, c.time_bin);
      end
      default: begin
        if (!grid_used[idx]) r.read_charge = grid_q[idx];
      end
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        results_due.push_back(grid_command({in_func, in_pad, in_time_bin, in_charge,
                                            in_hit_valid}));
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          in_func <= c.func;
          in_pad <= c.pad;
          in_time_bin <= c.time_bin;
          in_charge <= c.charge;
          in_hit_valid <= c.hit_valid;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor; long hold-offs are counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        res_t got, want;
        got = {out_found, out_charge_sum, out_pad_centre, out_time_centre,
               out_pad_variance, out_time_variance, out_pads_used, out_read_charge,
               out_saturated};
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %p", got);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
      if (hold_kick != hold_seen) begin
        hold_seen <= hold_kick;
        hold_cnt <= 2000;
        out_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  function automatic void queue_cmd(int f, int p, int t, int q, int hv);
    cmd_t c;
    c.func = 2'(f);
    c.pad = 8'(p);
    c.time_bin = 9'(t);
    c.charge = 10'(q);
    c.hit_valid = 1'(hv);
    pending_cmds.push_back(c);
  endfunction

  // written cluster with random shape, then a search near it and two reads
  function automatic int queue_cluster();
    int bp, bt, np, nt, n;
    bp = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 0 : 252) : $urandom_range(255);
    bt = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 0 : 506) : $urandom_range(511);
    np = $urandom_range(1, 4);
    nt = $urandom_range(1, 5);
    n = 0;
    for (int i = 0; i < np; i++)
      for (int j = 0; j < nt; j++) begin
        if (bp + i < NPADS && bt + j < NBINS && $urandom_range(5) != 0) begin
          queue_cmd(FUNC_WRITE, bp + i, bt + j,
                    $urandom_range(3) == 0 ? 1023 - $urandom_range(3) : $urandom_range(1023),
                    $urandom_range(1));
          n++;
        end
      end
    queue_cmd(FUNC_SEARCH, (bp + $urandom_range(4) + 254) % NPADS,
              (bt + $urandom_range(6) + 509) % NBINS, $urandom_range(1023),
              $urandom_range(15) != 0);
    queue_cmd(FUNC_READ, bp, bt, $urandom_range(1023), $urandom_range(1));
    queue_cmd(FUNC_READ, (bp + $urandom_range(4)) % NPADS, (bt + $urandom_range(5)) % NBINS,
              $urandom_range(1023), $urandom_range(1));
    return n + 3;
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || results_due.size() != 0 || !in_ready)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(int p, int pw, int tw);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_PADS_IN_ROW;
    cfg_wdata <= 9'(p);
    @(posedge clk);
    cfg_index <= REG_PAD_WINDOW;
    cfg_wdata <= 9'(pw);
    @(posedge clk);
    cfg_index <= REG_TIME_WINDOW;
    cfg_wdata <= 9'(tw);
    @(posedge clk);
    cfg_we <= 1'b0;
    row_pads = p;
    pad_win = pw;
    time_win = tw;
  endtask

  task automatic run_phase(int idle, int stall, int p, int pw, int tw, bit clear_first,
                           bit long_hold);
    int n;
    drain();
    write_regs(p, pw, tw);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    if (long_hold) hold_kick++;
    if (clear_first) queue_cmd(FUNC_CLEAR, 0, 0, 0, 0);
    n = 0;
    while (n < 225) begin
      if ($urandom_range(4) != 0) begin
        n += queue_cluster();
      end else begin
        queue_cmd($urandom_range(1, 3), $urandom_range(255), $urandom_range(511),
                  $urandom_range(1023), $urandom_range(1));
        n++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (!in_ready) @(posedge clk);

    // directed: extremes, every command, edges of the grid and of the windows
    queue_cmd(FUNC_READ, 17, 33, 0, 0);               // never written
    queue_cmd(FUNC_WRITE, 255, 511, 1023, 1);
    queue_cmd(FUNC_WRITE, 0, 0, 1023, 0);
    queue_cmd(FUNC_WRITE, 0, 1, 512, 1);
    queue_cmd(FUNC_WRITE, 1, 0, 1, 1);
    queue_cmd(FUNC_READ, 255, 511, 0, 1);
    queue_cmd(FUNC_SEARCH, 0, 0, 0, 0);               // hit_valid low
    queue_cmd(FUNC_SEARCH, 0, 2, 0, 1);               // walks to pad 0 and bin 0
    queue_cmd(FUNC_READ, 0, 0, 0, 0);                 // now used
    queue_cmd(FUNC_SEARCH, 1, 1, 0, 1);               // used cells summed again
    queue_cmd(FUNC_WRITE, 0, 0, 300, 1);              // rewrite clears used mark
    queue_cmd(FUNC_READ, 0, 0, 0, 1);
    queue_cmd(FUNC_SEARCH, 255, 511, 1023, 1);        // last pad, last bin
    queue_cmd(FUNC_SEARCH, 128, 256, 0, 1);           // empty area
    queue_cmd(FUNC_WRITE, 200, 300, 0, 0);            // zero charge digit
    queue_cmd(FUNC_READ, 200, 300, 0, 0);
    queue_cmd(FUNC_CLEAR, 255, 511, 1023, 1);
    queue_cmd(FUNC_READ, 255, 511, 0, 0);
    queue_cmd(FUNC_WRITE, 5, 5, 700, 0);
    drain();
    write_regs(5, 31, 63);
    queue_cmd(FUNC_SEARCH, 5, 5, 0, 1);               // seed at the pad bound
    queue_cmd(FUNC_SEARCH, 4, 3, 0, 1);
    queue_cmd(FUNC_READ, 5, 5, 0, 0);

    run_phase(0, 0, 256, 31, 63, 1'b0, 1'b1);
    run_phase(64, 0, 1, 0, 0, 1'b0, 1'b0);
    run_phase(0, 64, 120, 13, 20, 1'b1, 1'b0);
    run_phase(38, 38, 256, 6, 8, 1'b0, 1'b0);
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("track_seeded_cluster_search_unit_tb: clean");
    end else begin
      $display("track_seeded_cluster_search_unit_tb: errors");
    end
    $finish;
  end

endmodule
